[hw/rtl/mck_pkg.sv]
// ----------------------------------------------------------------------------
// mck_pkg
// shared types, command and status groups and the code rom of the keyer
// ----------------------------------------------------------------------------
package mck_pkg;

  localparam int CharWidth  = 8;
  localparam int CountWidth = 3;
  localparam int PatWidth   = 8;

  // rom covers '(' .. 'Z'; lower-case letters fold onto the letter entries
  localparam logic [CharWidth-1:0] RomLow      = 8'd40;
  localparam logic [CharWidth-1:0] RomHigh     = 8'd90;
  localparam logic [CharWidth-1:0] LowerLow    = 8'd97;
  localparam logic [CharWidth-1:0] LowerHigh   = 8'd122;
  localparam logic [CharWidth-1:0] LowerOffset = 8'd72;   // 97 - 25
  localparam logic [PatWidth-1:0]  LongMask    = 8'hC0;
  localparam logic [CountWidth-1:0] LongCount  = 3'd6;

  typedef struct packed {
    logic [CharWidth-1:0] character;
    logic                 end_of_text;
  } char_word_t;

  typedef struct packed {
    logic lamp_on;
    logic done_res;
    logic last;
  } key_word_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic shift;
    logic emit;
    logic lamp;
    logic done;
    logic last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic slot_free;
    logic elem_zero;
    logic msb;
  } sts_t;

  typedef struct packed {
    logic [CountWidth-1:0] count;
    logic [PatWidth-1:0]   pattern;
  } code_t;

  // packed codes, 1 bit is a dash, 0 bit a dot
  function automatic logic [PatWidth-1:0] rom_byte(input logic [5:0] idx);
    logic [PatWidth-1:0] b;
    case (idx)
      6'd0:  b = 8'h96;  6'd1:  b = 8'hED;  6'd2:  b = 8'hDA;  6'd3:  b = 8'h8A;
      6'd4:  b = 8'hF3;  6'd5:  b = 8'hE1;  6'd6:  b = 8'hD5;  6'd7:  b = 8'h92;
      6'd8:  b = 8'h9F;  6'd9:  b = 8'h8F;  6'd10: b = 8'h87;  6'd11: b = 8'h83;
      6'd12: b = 8'h81;  6'd13: b = 8'h80;  6'd14: b = 8'h90;  6'd15: b = 8'h98;
      6'd16: b = 8'h9C;  6'd17: b = 8'h9E;  6'd18: b = 8'hF8;  6'd19: b = 8'hEA;
      6'd20: b = 8'h96;  6'd21: b = 8'h91;  6'd22: b = 8'hED;  6'd23: b = 8'hCC;
      6'd24: b = 8'hDA;
      6'd25: b = 8'h28;  6'd26: b = 8'h70;  6'd27: b = 8'h74;  6'd28: b = 8'h50;
      6'd29: b = 8'h00;  6'd30: b = 8'h64;  6'd31: b = 8'h58;  6'd32: b = 8'h60;
      6'd33: b = 8'h20;  6'd34: b = 8'h6E;  6'd35: b = 8'h54;  6'd36: b = 8'h68;
      6'd37: b = 8'h38;  6'd38: b = 8'h30;  6'd39: b = 8'h5C;  6'd40: b = 8'h6C;
      6'd41: b = 8'h7A;  6'd42: b = 8'h48;  6'd43: b = 8'h40;  6'd44: b = 8'h10;
      6'd45: b = 8'h44;  6'd46: b = 8'h62;  6'd47: b = 8'h4C;  6'd48: b = 8'h72;
      6'd49: b = 8'h76;  6'd50: b = 8'h78;
      default: b = '0;
    endcase
    return b;
  endfunction

  // element count and left-aligned element pattern; count 0 means word space
  function automatic code_t code_lookup(input logic [CharWidth-1:0] ch);
    code_t               c;
    logic [CharWidth-1:0] idx;
    logic [PatWidth-1:0]  raw;
    logic                 hit;
    hit = 1'b1;
    idx = '0;
    if (ch >= RomLow && ch <= RomHigh) begin
      idx = ch - RomLow;
    end else if (ch >= LowerLow && ch <= LowerHigh) begin
      idx = ch - LowerOffset;
    end else begin
      hit = 1'b0;
    end
    raw = rom_byte(idx[5:0]);
    if (!hit) begin
      c.count   = '0;
      c.pattern = '0;
    end else if ((raw & LongMask) == LongMask) begin
      c.count   = LongCount;
      c.pattern = {raw[5:0], 2'b00};
    end else begin
      c.count   = raw[7:5] + 3'd1;
      c.pattern = {raw[4:0], 3'b000};
    end
    return c;
  endfunction

endpackage

[hw/rtl/mck_datapath.sv]
// ----------------------------------------------------------------------------
// mck_datapath
// element shift register, element counter and the output word register
// ----------------------------------------------------------------------------
module mck_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [mck_pkg::CharWidth-1:0]     character,
  input  mck_pkg::cmd_t                     cmd,
  output mck_pkg::sts_t                     sts,
  output logic                              key_valid,
  input  logic                              key_stall,
  output mck_pkg::key_word_t                key_word
);

  logic [mck_pkg::PatWidth-1:0]   symbol_shift;
  logic [mck_pkg::CountWidth-1:0] elements_left;
  mck_pkg::code_t                 code;

  assign code = mck_pkg::code_lookup(character);

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_shift  <= '0;
      elements_left <= '0;
      key_valid     <= 1'b0;
    end else begin
      if (cmd.load) begin
        symbol_shift  <= code.pattern;
        elements_left <= code.count;
      end else if (cmd.shift) begin
        symbol_shift  <= {symbol_shift[mck_pkg::PatWidth-2:0], 1'b0};
        elements_left <= elements_left - 3'd1;
      end
      if (cmd.emit) begin
        key_valid <= 1'b1;
      end else if (!key_stall) begin
        key_valid <= 1'b0;
      end
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      key_word.lamp_on  <= cmd.lamp;
      key_word.done_res <= cmd.done;
      key_word.last     <= cmd.last;
    end
  end

  assign sts.slot_free = !key_valid || !key_stall;
  assign sts.elem_zero = (elements_left == '0);
  assign sts.msb       = symbol_shift[mck_pkg::PatWidth-1];

endmodule

[hw/rtl/mck_ctrl.sv]
// ----------------------------------------------------------------------------
// mck_ctrl
// keying sequencer, one time unit per step while the output slot is free
// ----------------------------------------------------------------------------
module mck_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          char_valid,
  input  logic          end_of_text,
  output logic          busy,
  output mck_pkg::cmd_t cmd,
  input  mck_pkg::sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_OPEN,
    S_SPACE_A,
    S_SPACE_B,
    S_SPACE_C,
    S_NEXTSYM,
    S_DOT,
    S_DASH_A,
    S_DASH_B,
    S_DASH_C,
    S_EOT
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign busy   = (state != S_IDLE);
  assign accept = char_valid && !busy;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load   = !end_of_text;
          state_next = end_of_text ? S_EOT : S_OPEN;
        end
      end
      S_EOT: begin
        if (sts.slot_free) begin
          cmd.emit   = 1'b1;
          cmd.done   = 1'b1;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_OPEN: begin
        if (sts.slot_free) begin
          cmd.emit   = 1'b1;
          state_next = sts.elem_zero ? S_SPACE_A : S_NEXTSYM;
        end
      end
      S_SPACE_A: begin
        if (sts.slot_free) begin
          cmd.emit   = 1'b1;
          state_next = S_SPACE_B;
        end
      end
      S_SPACE_B: begin
        if (sts.slot_free) begin
          cmd.emit   = 1'b1;
          state_next = S_SPACE_C;
        end
      end
      S_SPACE_C: begin
        if (sts.slot_free) begin
          cmd.emit   = 1'b1;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_NEXTSYM: begin
        if (sts.slot_free) begin
          cmd.emit = 1'b1;
          if (sts.elem_zero) begin
            cmd.last   = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.shift  = 1'b1;
            state_next = sts.msb ? S_DASH_A : S_DOT;
          end
        end
      end
      S_DASH_A: begin
        if (sts.slot_free) begin
          cmd.emit   = 1'b1;
          cmd.lamp   = 1'b1;
          state_next = S_DASH_B;
        end
      end
      S_DASH_B: begin
        if (sts.slot_free) begin
          cmd.emit   = 1'b1;
          cmd.lamp   = 1'b1;
          state_next = S_DASH_C;
        end
      end
      S_DOT, S_DASH_C: begin
        if (sts.slot_free) begin
          cmd.emit   = 1'b1;
          cmd.lamp   = 1'b1;
          state_next = S_NEXTSYM;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[hw/rtl/morse_character_keyer_top.sv]
// ----------------------------------------------------------------------------
// morse_character_keyer_top
// morse keyer: one ascii character in, one keying word per time unit out
// ----------------------------------------------------------------------------
// each accepted character word is answered by a run of key words, one per
// time unit, with last set on the final one. a character opens with one off
// unit; each element is one off unit then one on unit (dot) or three on units
// (dash); one off unit closes it. codes outside '(' .. 'Z' and 'a' .. 'z' give
// four off units as a word space, and an end-of-text word gives a single word
// with done_res and last set. letters are case-insensitive. the block takes
// one character at a time: the sequencer takes the word while idle and then
// emits one key word per step while the output slot is free, so the longest
// character (six dashes) gives 26 key words, a word space 4 and end of text 1.
// the next character is taken as soon as the last key word sits in the output
// register.
module morse_character_keyer_top (
  input  logic                 clk,
  input  logic                 rst,
  // character side
  input  logic                 char_valid,
  output logic                 char_stall,
  input  mck_pkg::char_word_t  char_word,
  // keying side
  output logic                 key_valid,
  input  logic                 key_stall,
  output mck_pkg::key_word_t   key_word
);

  mck_pkg::cmd_t cmd;   // sequencer commands
  mck_pkg::sts_t sts;   // datapath status

  // sequencer: holds off new characters while keying is in progress
  mck_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .char_valid  (char_valid),
    .end_of_text (char_word.end_of_text),
    .busy        (char_stall),
    .cmd         (cmd),
    .sts         (sts)
  );

  // rom lookup, element shifter and output register
  mck_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .character (char_word.character),
    .cmd       (cmd),
    .sts       (sts),
    .key_valid (key_valid),
    .key_stall (key_stall),
    .key_word  (key_word)
  );

endmodule

[hw/rtl/mck_checker.sv]
// ----------------------------------------------------------------------------
// mck_port_checker
// port-level checks of the keyer, bound to the top level
// ----------------------------------------------------------------------------
module mck_port_checker (
  input logic                clk,
  input logic                rst,
  input logic                char_valid,
  input logic                char_stall,
  input mck_pkg::char_word_t char_word,
  input logic                key_valid,
  input logic                key_stall,
  input mck_pkg::key_word_t  key_word
);

  // output clears on reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !key_valid)
    else $error("key word valid right after reset");

  // stalled key word holds
  a_key_hold: assert property (@(posedge clk) disable iff (rst)
    key_valid && key_stall |=> key_valid && $stable(key_word))
    else $error("stalled key word changed");

  // taking a character blocks the next one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    char_valid && !char_stall |=> char_stall)
    else $error("character taken while keying");

  // done word is off and final
  a_done_form: assert property (@(posedge clk) disable iff (rst)
    key_valid && key_word.done_res |-> key_word.last && !key_word.lamp_on)
    else $error("malformed done word");

  // every character ends on an off unit
  a_last_off: assert property (@(posedge clk) disable iff (rst)
    key_valid && key_word.lamp_on |-> !key_word.last)
    else $error("character ends with key on");

endmodule

bind morse_character_keyer_top mck_port_checker u_mck_checker (
  .clk        (clk),
  .rst        (rst),
  .char_valid (char_valid),
  .char_stall (char_stall),
  .char_word  (char_word),
  .key_valid  (key_valid),
  .key_stall  (key_stall),
  .key_word   (key_word)
);
